// File: hw/rtl/hbx_pkg.sv
// shared types, codes and constant tables of the href span extractor
package hbx_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int START_W         = 24;
    localparam int LEN_W           = 16;
    localparam int BYTE_W          = 8;

    localparam logic [LEN_W-1:0] LIMIT_RESET  = 16'd4096;
    localparam logic             FILTER_RESET = 1'b1;
    localparam logic [LEN_W-1:0] LEN_MAX      = 16'hFFFF;

    // configuration register indexes
    localparam logic REG_LENGTH_LIMIT = 1'b0;
    localparam logic REG_SCHEME_FILTER = 1'b1;

    // parser phases
    localparam logic [1:0] PH_SCAN  = 2'd0;
    localparam logic [1:0] PH_QUOTE = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_HALT  = 2'd3;

    localparam logic [BYTE_W-1:0] CHR_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CHR_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CHR_EQUALS = 8'h3D;
    localparam logic [BYTE_W-1:0] CHR_CASE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_UP_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CHR_UP_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CHR_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CHR_LOW_H  = 8'h68;

    localparam logic [BYTE_W-1:0] HREF_WORD [4] = '{8'h68, 8'h72, 8'h65, 8'h66};

    localparam int N_SCHEME   = 4;
    localparam int SCHEME_MAX = 11;

    localparam logic [BYTE_W-1:0] SCHEME_TEXT [N_SCHEME][SCHEME_MAX] = '{
        '{"j", "a", "v", "a", "s", "c", "r", "i", "p", "t", ":"},
        '{"m", "a", "i", "l", "t", "o", ":", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "a", "t", "a", ":", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "e", "l", ":", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] SCHEME_LEN [N_SCHEME] = '{4'd11, 4'd7, 4'd5, 4'd4};

    typedef struct packed {
        logic [LEN_W-1:0] length_limit;
        logic             scheme_filter_on;
    } t_cfg;

    typedef struct packed {
        logic [LEN_W-1:0] value_length;
        logic             single_quoted;
    } t_span_info;

endpackage

// File: hw/rtl/hbx_scheme_check.sv
// prefix tracker for the blocked url schemes
module hbx_scheme_check
    import hbx_pkg::*;
(
    input  logic [BYTE_W-1:0]   i_byte,
    input  logic [LEN_W-1:0]    i_span_length,
    input  logic [N_SCHEME-1:0] i_alive,
    output logic [N_SCHEME-1:0] o_alive,
    output logic                o_hit
);

    logic [BYTE_W-1:0] lower;

    always_comb begin
        if (i_byte >= CHR_UP_A && i_byte <= CHR_UP_Z) begin
            lower = i_byte + CHR_CASE;
        end else begin
            lower = i_byte;
        end
    end

    always_comb begin
        o_alive = i_alive;
        o_hit   = 1'b0;
        for (int k = 0; k < N_SCHEME; k++) begin
            if (i_span_length < LEN_W'(SCHEME_LEN[k])) begin
                if (lower != SCHEME_TEXT[k][i_span_length[3:0]]) begin
                    o_alive[k] = 1'b0;
                end
            end
            if (i_alive[k] && i_span_length >= LEN_W'(SCHEME_LEN[k])) begin
                o_hit = 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/hbx_parser.sv
// per-byte parser state and span decision
module hbx_parser
    import hbx_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [BYTE_W-1:0]      i_byte,
    input  logic                   i_last,
    input  t_cfg                   i_cfg,
    output logic                   o_emit,
    output logic [OFFSET_BITS-1:0] o_start,
    output t_span_info             o_info
);

    logic [1:0]             r_phase,    n_phase;
    logic [2:0]             r_progress, n_progress;
    logic                   r_quote,    n_quote;
    logic [OFFSET_BITS-1:0] r_pos,      n_pos;
    logic [OFFSET_BITS-1:0] r_start,    n_start;
    logic [LEN_W-1:0]       r_len,      n_len;
    logic [N_SCHEME-1:0]    r_alive,    n_alive;

    logic [N_SCHEME-1:0]    chk_alive;
    logic                   chk_hit;
    logic [2:0]             scan_prog;
    logic                   scan_hit;
    logic [BYTE_W-1:0]      folded;
    logic [BYTE_W-1:0]      closer;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic                   drop;

    hbx_scheme_check u_scheme (
        .i_byte        (i_byte),
        .i_span_length (r_len),
        .i_alive       (r_alive),
        .o_alive       (chk_alive),
        .o_hit         (chk_hit)
    );

    assign folded  = i_byte | CHR_CASE;
    assign closer  = r_quote ? CHR_SQUOTE : CHR_DQUOTE;
    assign pos_inc = r_pos + OFFSET_BITS'(1);
    assign drop    = (r_len == '0) || (r_len >= i_cfg.length_limit) ||
                     (i_cfg.scheme_filter_on && chk_hit);

    // a failed quote restarts the match from nothing
    assign scan_prog = (r_phase == PH_QUOTE) ? 3'd0 : r_progress;

    always_comb begin
        if (scan_prog < 3'd4) begin
            scan_hit = (folded == HREF_WORD[scan_prog[1:0]]);
        end else begin
            scan_hit = (i_byte == CHR_EQUALS);
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_progress = r_progress;
        n_quote    = r_quote;
        n_start    = r_start;
        n_len      = r_len;
        n_alive    = r_alive;
        n_pos      = pos_inc;
        o_emit     = 1'b0;

        if (r_phase != PH_HALT) begin
            if (i_byte == CHR_NUL) begin
                n_phase = PH_HALT;
            end else if (r_phase == PH_VALUE) begin
                if (i_byte == closer) begin
                    o_emit     = !drop;
                    n_phase    = PH_SCAN;
                    n_progress = 3'd0;
                end else begin
                    n_alive = chk_alive;
                    if (r_len != LEN_MAX) begin
                        n_len = r_len + LEN_W'(1);
                    end
                end
            end else if (r_phase == PH_QUOTE &&
                         (i_byte == CHR_DQUOTE || i_byte == CHR_SQUOTE)) begin
                n_quote = (i_byte == CHR_SQUOTE);
                n_start = pos_inc;
                n_len   = '0;
                n_alive = '1;
                n_phase = PH_VALUE;
            end else begin
                n_phase = PH_SCAN;
                if (scan_hit) begin
                    if (scan_prog >= 3'd4) begin
                        n_progress = 3'd0;
                        n_phase    = PH_QUOTE;
                    end else begin
                        n_progress = scan_prog + 3'd1;
                    end
                end else begin
                    n_progress = (folded == CHR_LOW_H) ? 3'd1 : 3'd0;
                end
            end
        end

        if (i_last) begin
            n_phase    = PH_SCAN;
            n_progress = 3'd0;
            n_quote    = 1'b0;
            n_pos      = '0;
            n_start    = '0;
            n_len      = '0;
            n_alive    = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SCAN;
            r_progress <= 3'd0;
            r_quote    <= 1'b0;
            r_pos      <= '0;
            r_start    <= '0;
            r_len      <= '0;
            r_alive    <= '1;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_progress <= n_progress;
            r_quote    <= n_quote;
            r_pos      <= n_pos;
            r_start    <= n_start;
            r_len      <= n_len;
            r_alive    <= n_alive;
        end
    end

    assign o_start             = r_start;
    assign o_info.value_length = r_len;
    assign o_info.single_quoted = r_quote;

endmodule

// File: hw/rtl/html_href_span_extractor.sv
// top level of the href span extractor: input register, config, result register
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------------
//  in       | in        | i_in_valid / o_in_stall | i_text_byte, i_doc_last
//  out      | out       | o_out_valid / i_out_stall | o_value_start, o_value_length,
//           |           |                        | o_single_quoted
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one byte per cycle unless stalled; bytes pass the input, then the result register
// the parser step between the input and result registers sets the rate
// synchronous active-low reset clears parser state and restores register defaults
// a stalled result holds the parser; input then fills its register and stalls
module html_href_span_extractor
    import hbx_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_text_byte,
    input  logic               i_doc_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [START_W-1:0] o_value_start,
    output logic [LEN_W-1:0]   o_value_length,
    output logic               o_single_quoted,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [LEN_W-1:0]   i_cfg_data
);

    localparam int EXT_W = (OFFSET_BITS > START_W) ? OFFSET_BITS : START_W;

    t_cfg                   r_cfg;
    logic                   r_in_valid;
    logic [BYTE_W-1:0]      r_in_byte;
    logic                   r_in_last;
    logic                   r_out_valid;
    logic [START_W-1:0]     r_out_start;
    t_span_info             r_out_info;

    logic                   advance;
    logic                   emit;
    logic [OFFSET_BITS-1:0] span_start;
    logic [EXT_W-1:0]       start_ext;
    t_span_info             span_info;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign start_ext  = EXT_W'(span_start);

    hbx_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_cfg   (r_cfg),
        .o_emit  (emit),
        .o_start (span_start),
        .o_info  (span_info)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.length_limit     <= LIMIT_RESET;
            r_cfg.scheme_filter_on <= FILTER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LENGTH_LIMIT:  r_cfg.length_limit     <= i_cfg_data;
                REG_SCHEME_FILTER: r_cfg.scheme_filter_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_doc_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_start <= start_ext[START_W-1:0];
            r_out_info  <= span_info;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_value_start   = r_out_start;
    assign o_value_length  = r_out_info.value_length;
    assign o_single_quoted = r_out_info.single_quoted;

endmodule

// File: sim/testbench.sv
// self-checking testbench of the href span extractor with its own span predictor
`timescale 1ns / 1ps

module testbench;
    import hbx_pkg::*;

    typedef struct packed {
        logic [START_W-1:0] ofs;
        logic [LEN_W-1:0]   len;
        logic               sq;
    } span_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text;
        logic              last;
        logic              typed;
        span_t             span;
    } dir_row_t;

    localparam logic [BYTE_W-1:0] QUOTE_DQ = "\"";
    localparam logic [BYTE_W-1:0] QUOTE_SQ = "'";
    localparam logic [31:0]       HREF_STR = "href";
    localparam logic [8*11-1:0]   SCHEME_STR [4] = '{"javascript:", "mailto:", "data:", "tel:"};
    localparam int                SCHEME_CHARS [4] = '{11, 7, 5, 4};
    localparam int                SEG_BYTES = 135;

    localparam span_t NO_SPAN    = '0;
    localparam span_t FIRST_SPAN = '{24'd6, 16'd1, 1'b1};
    localparam int    N_ROWS     = 27;

    localparam dir_row_t DIRECTED [N_ROWS] = '{
        '{"H", 1'b0, 1'b0, NO_SPAN},
        '{"r", 1'b0, 1'b0, NO_SPAN},
        '{"E", 1'b0, 1'b0, NO_SPAN},
        '{"f", 1'b0, 1'b0, NO_SPAN},
        '{"=", 1'b0, 1'b0, NO_SPAN},
        '{"'", 1'b0, 1'b0, NO_SPAN},
        '{8'hFF, 1'b0, 1'b0, NO_SPAN},
        '{"'", 1'b0, 1'b1, FIRST_SPAN},
        '{"h", 1'b0, 1'b0, NO_SPAN},
        '{"r", 1'b0, 1'b0, NO_SPAN},
        '{"e", 1'b0, 1'b0, NO_SPAN},
        '{"f", 1'b0, 1'b0, NO_SPAN},
        '{"=", 1'b0, 1'b0, NO_SPAN},
        '{"\"", 1'b0, 1'b0, NO_SPAN},
        '{"T", 1'b0, 1'b0, NO_SPAN},
        '{"e", 1'b0, 1'b0, NO_SPAN},
        '{"L", 1'b0, 1'b0, NO_SPAN},
        '{":", 1'b0, 1'b0, NO_SPAN},
        '{"\"", 1'b1, 1'b0, NO_SPAN},
        '{"h", 1'b0, 1'b0, NO_SPAN},
        '{"r", 1'b0, 1'b0, NO_SPAN},
        '{"e", 1'b0, 1'b0, NO_SPAN},
        '{"f", 1'b0, 1'b0, NO_SPAN},
        '{"=", 1'b0, 1'b0, NO_SPAN},
        '{"\"", 1'b0, 1'b0, NO_SPAN},
        '{8'h00, 1'b0, 1'b0, NO_SPAN},
        '{"\"", 1'b1, 1'b0, NO_SPAN}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_text_byte;
    logic               i_doc_last;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [START_W-1:0] o_value_start;
    logic [LEN_W-1:0]   o_value_length;
    logic               o_single_quoted;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [LEN_W-1:0]   i_cfg_data;

    logic [1:0]                 doc_phase;
    logic [2:0]                 href_prog;
    logic                       quote_single;
    logic [OFFSET_BITS_DEF-1:0] doc_pos;
    logic [OFFSET_BITS_DEF-1:0] span_ofs;
    logic [LEN_W-1:0]           span_len;
    logic [3:0]                 scheme_alive;
    logic [LEN_W-1:0]           cfg_limit;
    logic                       cfg_filter;

    span_t span_queue [$];
    int    fail_count;
    int    spans_checked;
    int    bytes_sent;
    int    docs_sent;
    int    cfg_writes;
    bit    steady;
    bit    hold_req;

    html_href_span_extractor i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_text_byte     (i_text_byte),
        .i_doc_last      (i_doc_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_value_start   (o_value_start),
        .o_value_length  (o_value_length),
        .o_single_quoted (o_single_quoted),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic void restart_doc();
        doc_phase    = PH_SCAN;
        href_prog    = 3'd0;
        quote_single = 1'b0;
        doc_pos      = '0;
        span_ofs     = '0;
        span_len     = '0;
        scheme_alive = 4'hF;
    endfunction

    function automatic void match_href(input logic [BYTE_W-1:0] c);
        logic hit;
        if (href_prog < 3'd4) begin
            hit = ((c | 8'h20) == HREF_STR[8*(3-href_prog) +: 8]);
        end else begin
            hit = (c == "=");
        end
        if (hit) begin
            if (href_prog >= 3'd4) begin
                href_prog = 3'd0;
                doc_phase = PH_QUOTE;
            end else begin
                href_prog = href_prog + 3'd1;
            end
        end else begin
            href_prog = ((c | 8'h20) == "h") ? 3'd1 : 3'd0;
        end
    endfunction

    task automatic track_byte(input logic [BYTE_W-1:0] c, input logic last,
                              output logic got, output span_t sp);
        logic [BYTE_W-1:0] lc;
        logic              scheme_hit;
        int                k;
        got = 1'b0;
        sp  = NO_SPAN;
        if (doc_phase != PH_HALT) begin
            if (c == 8'h00) begin
                doc_phase = PH_HALT;
            end else if (doc_phase == PH_QUOTE) begin
                if (c == QUOTE_DQ || c == QUOTE_SQ) begin
                    quote_single = (c == QUOTE_SQ);
                    span_ofs     = doc_pos + OFFSET_BITS_DEF'(1);
                    span_len     = '0;
                    scheme_alive = 4'hF;
                    doc_phase    = PH_VALUE;
                end else begin
                    doc_phase = PH_SCAN;
                    href_prog = 3'd0;
                    match_href(c);
                end
            end else if (doc_phase == PH_VALUE) begin
                if (c == (quote_single ? QUOTE_SQ : QUOTE_DQ)) begin
                    scheme_hit = 1'b0;
                    for (k = 0; k < 4; k++) begin
                        if (scheme_alive[k] && span_len >= SCHEME_CHARS[k]) begin
                            scheme_hit = 1'b1;
                        end
                    end
                    if (span_len != 0 && span_len < cfg_limit && !(cfg_filter && scheme_hit)) begin
                        got    = 1'b1;
                        sp.ofs = span_ofs[START_W-1:0];
                        sp.len = span_len;
                        sp.sq  = quote_single;
                    end
                    doc_phase = PH_SCAN;
                    href_prog = 3'd0;
                end else begin
                    lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
                    for (k = 0; k < 4; k++) begin
                        if (span_len < SCHEME_CHARS[k] &&
                            lc != SCHEME_STR[k][8*(SCHEME_CHARS[k]-1-span_len) +: 8]) begin
                            scheme_alive[k] = 1'b0;
                        end
                    end
                    if (span_len != 16'hFFFF) begin
                        span_len = span_len + LEN_W'(1);
                    end
                end
            end else begin
                match_href(c);
            end
        end
        doc_pos = doc_pos + OFFSET_BITS_DEF'(1);
        if (last) begin
            restart_doc();
        end
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] c, input logic last,
                            input logic typed, input span_t typed_span);
        logic  got;
        span_t sp;
        while (!steady && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= c;
        i_doc_last  <= last;
        do @(posedge i_clk); while (o_in_stall);
        track_byte(c, last, got, sp);
        if (typed) begin
            span_queue.push_back(typed_span);
        end else if (got) begin
            span_queue.push_back(sp);
        end
        bytes_sent++;
        if (last) begin
            docs_sent++;
        end
    endtask

    task automatic drain_spans();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (span_queue.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (span_queue.size() != 0) begin
            $display("%0d expected spans never arrived", span_queue.size());
            fail_count += span_queue.size();
            span_queue.delete();
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [LEN_W-1:0] limit, input logic filter);
        logic [14:0] junk;
        junk = 15'($urandom());
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_LENGTH_LIMIT;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_limit = limit;
        i_cfg_index <= REG_SCHEME_FILTER;
        i_cfg_data  <= {junk, filter};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_filter = filter;
        i_cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    task automatic send_long_value(input int n, input logic [BYTE_W-1:0] q);
        logic [BYTE_W-1:0] b;
        int                i;
        for (i = 0; i < 4; i++) begin
            put_byte(HREF_STR[8*(3-i) +: 8], 1'b0, 1'b0, NO_SPAN);
        end
        put_byte("=", 1'b0, 1'b0, NO_SPAN);
        put_byte(q, 1'b0, 1'b0, NO_SPAN);
        repeat (n) begin
            do b = BYTE_W'($urandom_range(1, 255)); while (b == q);
            put_byte(b, 1'b0, 1'b0, NO_SPAN);
        end
        put_byte(q, 1'b1, 1'b0, NO_SPAN);
    endtask

    task automatic send_random_doc();
        logic [BYTE_W-1:0] doc_text [$];
        logic [BYTE_W-1:0] q;
        logic [BYTE_W-1:0] b;
        int                kind;
        int                n;
        int                k;
        int                i;
        repeat ($urandom_range(1, 6)) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                for (i = 0; i < 4; i++) begin
                    doc_text.push_back(HREF_STR[8*(3-i) +: 8] ^ ($urandom_range(1) ? 8'h20 : 8'h00));
                end
                doc_text.push_back("=");
                q = $urandom_range(1) ? QUOTE_SQ : QUOTE_DQ;
                doc_text.push_back(q);
                if ($urandom_range(3) == 0) begin
                    k = $urandom_range(3);
                    n = $urandom_range(1, SCHEME_CHARS[k]);
                    for (i = 0; i < n; i++) begin
                        b = SCHEME_STR[k][8*(SCHEME_CHARS[k]-1-i) +: 8];
                        if (b == ":" && $urandom_range(4) == 0) begin
                            b = ";";
                        end else if (b >= "a" && b <= "z" && $urandom_range(1)) begin
                            b = b - 8'h20;
                        end
                        doc_text.push_back(b);
                    end
                end
                n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                repeat (n) begin
                    do begin
                        b = ($urandom_range(3) == 0) ? BYTE_W'($urandom_range(1, 255))
                                                     : BYTE_W'($urandom_range(32, 126));
                    end while (b == q);
                    doc_text.push_back(b);
                end
                // an unclosed value now and then
                if (kind < 60) begin
                    doc_text.push_back(q);
                end
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(1)) begin
                        doc_text.push_back(BYTE_W'($urandom_range(1, 255)));
                    end else begin
                        doc_text.push_back(HREF_STR[8*$urandom_range(3) +: 8]);
                    end
                end
            end else if (kind < 92) begin
                for (i = 0; i < 4; i++) begin
                    doc_text.push_back(HREF_STR[8*(3-i) +: 8] ^ ($urandom_range(1) ? 8'h20 : 8'h00));
                end
                case ($urandom_range(2))
                    0: begin
                        doc_text.push_back("=");
                        do b = BYTE_W'($urandom_range(1, 255));
                        while (b == QUOTE_SQ || b == QUOTE_DQ);
                        doc_text.push_back(b);
                    end
                    1: begin
                        doc_text.push_back(" ");
                        doc_text.push_back("=");
                    end
                    default: begin
                        doc_text.push_back("h");
                    end
                endcase
            end else begin
                doc_text.push_back(8'h00);
                doc_text.push_back(BYTE_W'($urandom_range(1, 255)));
            end
        end
        for (i = 0; i < doc_text.size(); i++) begin
            put_byte(doc_text[i], i == doc_text.size() - 1, 1'b0, NO_SPAN);
        end
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady && ($urandom_range(99) < 19);
            end
        end
    end

    always @(posedge i_clk) begin
        span_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (span_queue.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected span: start %0d length %0d single %0b",
                             o_value_start, o_value_length, o_single_quoted);
                end
                fail_count++;
            end else begin
                want = span_queue.pop_front();
                spans_checked++;
                if (o_value_start !== want.ofs || o_value_length !== want.len ||
                    o_single_quoted !== want.sq) begin
                    if (fail_count < 10) begin
                        $display("span mismatch: expected start %0d length %0d single %0b, got %0d %0d %0b",
                                 want.ofs, want.len, want.sq,
                                 o_value_start, o_value_length, o_single_quoted);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int               r;
        int               seg;
        int               seg_start;
        logic [LEN_W-1:0] limit;
        logic             filter;
        bit               paused;
        fail_count    = 0;
        spans_checked = 0;
        bytes_sent    = 0;
        docs_sent     = 0;
        cfg_writes    = 0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        paused        = 1'b0;
        cfg_limit     = 16'd4096;
        cfg_filter    = 1'b1;
        restart_doc();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_text_byte <= 8'h00;
        i_doc_last  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_LENGTH_LIMIT;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_ROWS; r++) begin
            put_byte(DIRECTED[r].text, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].span);
        end
        drain_spans();

        // longest kept value under a short limit, then the first dropped length and a longer one
        load_config(16'd24, 1'b0);
        steady = 1'b1;
        send_long_value(23, QUOTE_DQ);
        send_long_value(24, QUOTE_SQ);
        send_long_value(30, QUOTE_DQ);
        steady = 1'b0;
        drain_spans();

        for (seg = 0; seg < 8; seg++) begin
            case (seg)
                0: begin limit = 16'd65535; filter = 1'b0; end
                1: begin limit = 16'd8;     filter = 1'b1; end
                2: begin limit = 16'd1;     filter = 1'b1; end
                3: begin limit = 16'd0;     filter = 1'b0; end
                4: begin limit = 16'd4096;  filter = 1'b1; end
                5: begin
                    limit  = LEN_W'($urandom_range(2, 16));
                    filter = 1'($urandom_range(1));
                end
                6: begin limit = 16'd65535; filter = 1'b1; end
                default: begin
                    limit  = LEN_W'($urandom_range(1, 65535));
                    filter = 1'($urandom_range(1));
                end
            endcase
            load_config(limit, filter);
            if (seg == 1) begin
                hold_req = 1'b1;
            end
            steady    = (seg == 4);
            seg_start = bytes_sent;
            while (bytes_sent - seg_start < SEG_BYTES) begin
                send_random_doc();
                if (seg == 6 && !paused && bytes_sent - seg_start >= SEG_BYTES / 2) begin
                    drain_spans();
                    paused = 1'b1;
                end
            end
            steady = 1'b0;
            drain_spans();
        end

        $display("%0d bytes in %0d documents, %0d spans checked, %0d register writes",
                 bytes_sent, docs_sent, spans_checked, cfg_writes);
        $display("covered both quote kinds, scheme prefixes, halts, unclosed values, limits 0 to 65535");
        if (fail_count == 0) begin
            $display("html_href_span_extractor verification clean");
        end else begin
            $display("html_href_span_extractor verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("html_href_span_extractor verification failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/hbx_pkg.sv
hw/rtl/hbx_scheme_check.sv
hw/rtl/hbx_parser.sv
hw/rtl/html_href_span_extractor.sv
sim/testbench.sv
